[hdl/assert_macros.svh]
// assertion macros for the rtl files (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/llro_pkg.sv]
// package: fixed-point exp helpers for the decay factor table
`default_nettype none

package llro_pkg;

  localparam int unsigned TAYLOR_TERMS = 24;

  // exp(-f), f in q0.32, result in q32.32
  function automatic logic [63:0] exp_frac(input logic [31:0] f);
    logic [127:0] prod;
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  neg;
    term = 64'h1_0000_0000;
    pos  = 64'h1_0000_0000;
    neg  = 64'd0;
    for (int j = 1; j <= TAYLOR_TERMS; j++) begin
      prod = 128'(term) * 128'(f);
      term = 64'(prod >> 32) / 64'(j);
      if ((j % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? (pos - neg) : 64'd0;
  endfunction

  localparam logic [63:0]  EXP_HALF = exp_frac(32'h8000_0000);
  localparam logic [127:0] EXP_HALF_SQ = 128'(EXP_HALF) * 128'(EXP_HALF) + 128'h8000_0000;
  // exp(-1) in q0.32
  localparam logic [63:0]  EXP_ONE = 64'(EXP_HALF_SQ >> 32);

  // table entry from the exponent magnitude y in q32.32, rounded into q0.16
  function automatic logic [15:0] exp_entry(input logic [63:0] y);
    logic [63:0]  n;
    logic [63:0]  r;
    logic [127:0] prod;
    logic [63:0]  q;
    n = y >> 32;
    if (n >= 64'd32) begin
      return 16'd0;
    end
    r = exp_frac(y[31:0]);
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < n) begin
        prod = 128'(r) * 128'(EXP_ONE) + 128'h8000_0000;
        r    = 64'(prod >> 32);
      end
    end
    q = (r + 64'h8000) >> 16;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

endpackage

`default_nettype wire

[hdl/lake_linear_reservoir_outflow.sv]
// top level: pipelined linear-reservoir lake outflow
//
// usage
//   input stream: one transfer per reservoir and time step carrying stored
//   volume, inflow, capacity (unsigned q24.8) and storage time constant (q8.8)
//   output stream: one transfer per input with the total outflow in q26.8,
//   i.e. initial release plus the overflow above capacity before and after
//   the step
//   pipeline: eight register stages from the input transfer to out_tvalid
//   (table lookup, interpolation, release and coefficient multiply, round and
//   clamp, inflow split multiply, sum, new storage, overflow and total)
//   throughput: one item per cycle while out_tready holds; each stage advances when it is empty or
//   the stage after it advances, so bubbles collapse
//   a stalled receiver holds the output register; items behind it pile up
//   stage by stage and in_tready falls only once every stage is full
//   reset clears all stage valid bits; the exp table is constant logic built
//   at elaboration, so no fill or clearing pass follows reset
`default_nettype none

module lake_linear_reservoir_outflow
  import llro_pkg::*;
#(
  parameter int unsigned VOLUME_WIDTH    = 32,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // fields from bit 0: water_volume, inflow_volume, capacity_volume, store_factor
  input  wire logic [((3*VOLUME_WIDTH+16+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // fields from bit 0: outflow_volume
  output logic [((VOLUME_WIDTH+2+7)/8)*8-1:0] out_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready
);

  `include "assert_macros.svh"

  localparam int unsigned VW     = VOLUME_WIDTH;
  localparam int unsigned OW     = VOLUME_WIDTH + 2;
  localparam int unsigned OUT_TW = ((VOLUME_WIDTH + 2 + 7) / 8) * 8;
  localparam int unsigned NSTG   = 8;
  localparam int unsigned IDXW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned PW     = 16 + IDXW;

  // decay factor table, t[k] = exp(-depth/(256k)) in q0.16
  logic [15:0] exp_tab [EXP_TABLE_DEPTH+1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    if (k == 0) begin : g_zero
      assign exp_tab[k] = 16'd0;
    end else begin : g_ent
      localparam logic [63:0] Y = (64'(EXP_TABLE_DEPTH) << 32) / (64'd256 * 64'(k));
      assign exp_tab[k] = exp_entry(Y);
    end
  end

  // stage valids and advance chain
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // input unpack
  logic [VW-1:0] in_w, in_i, in_c;
  logic [15:0]   in_s;
  assign in_w = in_tdata[VW-1:0];
  assign in_i = in_tdata[2*VW-1:VW];
  assign in_c = in_tdata[3*VW-1:2*VW];
  assign in_s = in_tdata[3*VW+15:3*VW];

  // stage 1: clip to capacity, table lookup
  logic [PW-1:0]   p_pos;
  logic [IDXW-1:0] idx;
  logic [15:0]     t_lo, t_hi;
  assign p_pos = PW'(in_s) * PW'(EXP_TABLE_DEPTH);
  assign idx   = IDXW'(p_pos >> 16);
  assign t_lo  = exp_tab[idx];
  assign t_hi  = exp_tab[idx + IDXW'(1)];

  logic [VW-1:0] wc1_r, inf1_r, cap1_r, ov11_r;
  logic [15:0]   s1_r, lo1_r, d1_r, f1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      wc1_r  <= (in_w > in_c) ? in_c : in_w;
      ov11_r <= (in_w > in_c) ? (in_w - in_c) : '0;
      inf1_r <= in_i;
      cap1_r <= in_c;
      s1_r   <= in_s;
      lo1_r  <= t_lo;
      d1_r   <= (t_hi > t_lo) ? (t_hi - t_lo) : 16'd0;
      f1_r   <= p_pos[15:0];
    end
  end

  // stage 2: interpolate e, form 1-e
  logic [31:0] interp;
  logic [15:0] e2;
  assign interp = 32'(d1_r) * 32'(f1_r) + 32'h8000;
  assign e2     = lo1_r + interp[31:16];

  logic [VW-1:0] wc2_r, inf2_r, cap2_r, ov12_r;
  logic [15:0]   s2_r;
  logic [16:0]   om2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      wc2_r  <= wc1_r;
      inf2_r <= inf1_r;
      cap2_r <= cap1_r;
      ov12_r <= ov11_r;
      s2_r   <= s1_r;
      om2_r  <= 17'h1_0000 - 17'(e2);
    end
  end

  // stage 3: storage release and inflow coefficient products
  logic [VW-1:0]  wc3_r, inf3_r, cap3_r, ov13_r;
  logic [VW+16:0] araw3_r;
  logic [32:0]    sm3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      wc3_r   <= wc2_r;
      inf3_r  <= inf2_r;
      cap3_r  <= cap2_r;
      ov13_r  <= ov12_r;
      araw3_r <= (VW+17)'(wc2_r) * (VW+17)'(om2_r);
      sm3_r   <= 33'(s2_r) * 33'(om2_r);
    end
  end

  // stage 4: round release, clamp coefficient
  logic [VW+16:0] araw_rnd;
  assign araw_rnd = araw3_r + (VW+17)'(17'h8000);

  logic [VW-1:0] wc4_r, inf4_r, cap4_r, ov14_r, a4_r;
  logic [24:0]   g4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      wc4_r  <= wc3_r;
      inf4_r <= inf3_r;
      cap4_r <= cap3_r;
      ov14_r <= ov13_r;
      a4_r   <= VW'(araw_rnd >> 16);
      g4_r   <= (sm3_r < 33'h100_0000) ? 25'(33'h100_0000 - sm3_r) : 25'd0;
    end
  end

  // stage 5: inflow times coefficient, split at bit 24
  logic [VW+23:0] inf_x;
  assign inf_x = (VW+24)'(inf4_r);

  logic [VW-1:0]  wc5_r, inf5_r, cap5_r, ov15_r, a5_r;
  logic [VW+24:0] bh5_r;
  logic [48:0]    bl5_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      wc5_r  <= wc4_r;
      inf5_r <= inf4_r;
      cap5_r <= cap4_r;
      ov15_r <= ov14_r;
      a5_r   <= a4_r;
      bh5_r  <= (VW+25)'(inf_x[VW+23:24]) * (VW+25)'(g4_r);
      bl5_r  <= 49'(inf_x[23:0]) * 49'(g4_r);
    end
  end

  // stage 6: initial outflow
  logic [48:0] bl_rnd;
  assign bl_rnd = bl5_r + 49'h80_0000;

  logic [VW-1:0] wc6_r, inf6_r, cap6_r, ov16_r;
  logic [OW-1:0] o6_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      wc6_r  <= wc5_r;
      inf6_r <= inf5_r;
      cap6_r <= cap5_r;
      ov16_r <= ov15_r;
      o6_r   <= OW'(a5_r) + OW'(bh5_r) + OW'(bl_rnd >> 24);
    end
  end

  // stage 7: new storage, clamped at zero
  logic [OW-1:0] nw_sum;
  assign nw_sum = OW'(wc6_r) + OW'(inf6_r);

  logic [VW-1:0] cap7_r, ov17_r;
  logic [OW-1:0] o7_r, nw7_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      cap7_r <= cap6_r;
      ov17_r <= ov16_r;
      o7_r   <= o6_r;
      nw7_r  <= (nw_sum > o6_r) ? (nw_sum - o6_r) : '0;
    end
  end

  // stage 8: second overflow and total, output register
  logic [OW-1:0] ov2;
  assign ov2 = (nw7_r > OW'(cap7_r)) ? (nw7_r - OW'(cap7_r)) : '0;

  logic [OW-1:0] out8_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      out8_r <= o7_r + OW'(ov17_r) + ov2;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = OUT_TW'(out8_r);

  // checks
  `ASSERT_NEXT(a_in_enters, in_tvalid && in_tready, v_r[0],
    "accepted transfer did not enter stage 1")
  `ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid && !out_tready && (&v_r),
    "input stalled without a full pipeline behind a stalled output")
  `ASSERT_NEXT(a_stage1_hold, v_r[0] && !adv[0] && rst_n, v_r[0] && $stable(s1_r),
    "stalled stage 1 lost or changed its item")

endmodule

`default_nettype wire
